// ===== hw/rtl/ppm_pkg.sv =====
// Package for the PPM frame decoder: constants, operation, status and register codes,
// and the structs passed between the decoder modules. No dependencies.
package ppm_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [15:0] SYNC_MIN_RST    = 16'd7000;
    localparam logic [15:0] SYNC_MAX_RST    = 16'd16000;
    localparam logic [15:0] CHAN_MIN_RST    = 16'd750;
    localparam logic [15:0] CHAN_MAX_RST    = 16'd2400;
    localparam logic [15:0] NOISE_DELTA_RST = 16'd300;
    localparam logic [15:0] FRAME_TO_RST    = 16'd32;
    localparam logic [15:0] VALID_TO_RST    = 16'd64;
    localparam logic [7:0]  MIN_FRAMES_RST  = 8'd4;

    localparam logic [6:0]  PULSE_IDX_MAX = 7'd127;
    localparam logic [31:0] TIMER_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_TICK = 2'd1,
        OP_POLL = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_CHAN = 2'd1,
        ST_STALE   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_MIN    = 8'd0,
        REG_SYNC_MAX    = 8'd1,
        REG_CHAN_MIN    = 8'd2,
        REG_CHAN_MAX    = 8'd3,
        REG_NOISE_DELTA = 8'd4,
        REG_FRAME_TO    = 8'd5,
        REG_VALID_TO    = 8'd6,
        REG_MIN_FRAMES  = 8'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] sync_min_us;
        logic [15:0] sync_max_us;
        logic [15:0] chan_min_us;
        logic [15:0] chan_max_us;
        logic [15:0] noise_delta_us;
        logic [15:0] frame_timeout_ms;
        logic [15:0] valid_timeout_ms;
        logic [7:0]  min_frames;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [15:0] capture_time;
        logic [7:0]  channel;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] channel_width;
        logic [31:0] frame_number;
        logic [6:0]  channels_found;
        logic [7:0]  noise_count;
        logic [15:0] last_sync_width;
    } t_result;

endpackage

// ===== hw/rtl/ppm_if.sv =====
// Channel interfaces of the PPM frame decoder: input items, results, register writes.
// Depends on ppm_pkg for the register index width.
interface ppm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] capture_time;
    logic [7:0]  channel;

    modport source (output valid, operation, capture_time, channel, input ready);
    modport sink   (input valid, operation, capture_time, channel, output ready);
endinterface

interface ppm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] channel_width;
    logic [31:0] frame_number;
    logic [6:0]  channels_found;
    logic [7:0]  noise_count;
    logic [15:0] last_sync_width;

    modport source (output valid, status, channel_width, frame_number, channels_found,
                    noise_count, last_sync_width, input ready);
    modport sink   (input valid, status, channel_width, frame_number, channels_found,
                    noise_count, last_sync_width, output ready);
endinterface

interface ppm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ppm_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ppm_cfg_regs.sv =====
// Configuration register file of the PPM frame decoder.
// Depends on ppm_pkg for t_cfg, register codes and reset values.
module ppm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [ppm_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [15:0]                   i_data,
    output ppm_pkg::t_cfg                 o_cfg
);
    import ppm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_min_us      <= SYNC_MIN_RST;
            r_cfg.sync_max_us      <= SYNC_MAX_RST;
            r_cfg.chan_min_us      <= CHAN_MIN_RST;
            r_cfg.chan_max_us      <= CHAN_MAX_RST;
            r_cfg.noise_delta_us   <= NOISE_DELTA_RST;
            r_cfg.frame_timeout_ms <= FRAME_TO_RST;
            r_cfg.valid_timeout_ms <= VALID_TO_RST;
            r_cfg.min_frames       <= MIN_FRAMES_RST;
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_SYNC_MIN:    r_cfg.sync_min_us      <= i_data;
                REG_SYNC_MAX:    r_cfg.sync_max_us      <= i_data;
                REG_CHAN_MIN:    r_cfg.chan_min_us      <= i_data;
                REG_CHAN_MAX:    r_cfg.chan_max_us      <= i_data;
                REG_NOISE_DELTA: r_cfg.noise_delta_us   <= i_data;
                REG_FRAME_TO:    r_cfg.frame_timeout_ms <= i_data;
                REG_VALID_TO:    r_cfg.valid_timeout_ms <= i_data;
                REG_MIN_FRAMES:  r_cfg.min_frames       <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/ppm_core.sv =====
// Decoder state and single-pass update logic for one transaction of the PPM frame decoder.
// Depends on ppm_pkg for t_cfg, t_item, t_result and the code enums.
module ppm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ppm_pkg::t_item   i_item,
    input  ppm_pkg::t_cfg    i_cfg,
    output ppm_pkg::t_result o_result
);
    import ppm_pkg::*;

    logic [15:0] r_prev_cap;
    logic [15:0] r_sync_width;
    logic        r_active;
    logic [6:0]  r_pulse_idx;
    logic [6:0]  r_detected;
    logic [7:0]  r_noisy;
    logic [31:0] r_frame_cnt;
    logic [31:0] r_reported;
    logic [31:0] r_valid_tmr;
    logic [31:0] r_gap_tmr;
    logic [15:0] r_pending   [CHANNELS];
    logic [15:0] r_published [CHANNELS];

    logic [15:0] n_prev_cap;
    logic [15:0] n_sync_width;
    logic        n_active;
    logic [6:0]  n_pulse_idx;
    logic [6:0]  n_detected;
    logic [7:0]  n_noisy;
    logic [31:0] n_frame_cnt;
    logic [31:0] n_reported;
    logic [31:0] n_valid_tmr;
    logic [31:0] n_gap_tmr;
    logic [15:0] n_pending   [CHANNELS];
    logic [15:0] n_published [CHANNELS];
    t_result     n_result;

    always_comb begin
        logic [15:0] w;
        logic [15:0] old_w;
        logic [15:0] delta;
        n_prev_cap   = r_prev_cap;
        n_sync_width = r_sync_width;
        n_active     = r_active;
        n_pulse_idx  = r_pulse_idx;
        n_detected   = r_detected;
        n_noisy      = r_noisy;
        n_frame_cnt  = r_frame_cnt;
        n_reported   = r_reported;
        n_valid_tmr  = r_valid_tmr;
        n_gap_tmr    = r_gap_tmr;
        n_pending    = r_pending;
        n_published  = r_published;
        n_result     = '0;
        w     = i_item.capture_time - r_prev_cap;
        old_w = r_pending[r_pulse_idx[CH_IDX_W-1:0]];
        delta = (w >= old_w) ? (w - old_w) : (old_w - w);

        unique case (i_item.op)
            OP_EDGE: begin
                n_prev_cap = i_item.capture_time;
                if (w >= i_cfg.sync_min_us) begin
                    if (w <= i_cfg.sync_max_us) begin
                        if (r_active && (r_pulse_idx != 7'd0)) begin
                            if ((r_detected != 7'd0) && (r_pulse_idx == r_detected)) begin
                                n_published = r_pending;
                            end
                            n_detected  = r_pulse_idx;
                            n_valid_tmr = '0;
                            n_frame_cnt = r_frame_cnt + 32'd1;
                        end
                        n_noisy     = '0;
                        n_active    = 1'b1;
                        n_pulse_idx = '0;
                        n_gap_tmr   = '0;
                    end
                    n_sync_width = w;
                end else if ((r_sync_width != 16'd0) && r_active) begin
                    if ((w >= i_cfg.chan_min_us) && (w <= i_cfg.chan_max_us)) begin
                        if (r_pulse_idx < 7'(CHANNELS)) begin
                            if (delta >= i_cfg.noise_delta_us) begin
                                n_noisy = r_noisy + 8'd1;
                            end
                            n_pending[r_pulse_idx[CH_IDX_W-1:0]] = w;
                        end
                        if (r_pulse_idx != PULSE_IDX_MAX) begin
                            n_pulse_idx = r_pulse_idx + 7'd1;
                        end
                        n_gap_tmr = '0;
                    end else begin
                        n_frame_cnt = '0;
                        n_active    = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (r_valid_tmr != TIMER_MAX) begin
                    n_valid_tmr = r_valid_tmr + 32'd1;
                end
                if (r_gap_tmr != TIMER_MAX) begin
                    n_gap_tmr = r_gap_tmr + 32'd1;
                end
                if ((n_gap_tmr > {16'd0, i_cfg.frame_timeout_ms}) && (r_sync_width != 16'd0)) begin
                    n_sync_width = '0;
                    n_detected   = '0;
                    n_active     = 1'b0;
                    n_noisy      = '0;
                    n_frame_cnt  = '0;
                end
            end
            OP_POLL: begin
                if ((r_frame_cnt >= {24'd0, i_cfg.min_frames}) && (r_frame_cnt != r_reported)) begin
                    n_reported            = r_frame_cnt;
                    n_result.frame_number = r_frame_cnt;
                end
            end
            OP_READ: begin
                priority if ((i_item.channel >= 8'(CHANNELS))
                             || (i_item.channel >= {1'b0, r_detected})) begin
                    n_result.status = ST_NO_CHAN;
                end else if (r_valid_tmr > {16'd0, i_cfg.valid_timeout_ms}) begin
                    n_result.status = ST_STALE;
                end else begin
                    n_result.channel_width = r_published[i_item.channel[CH_IDX_W-1:0]];
                end
            end
            default: begin
            end
        endcase

        n_result.channels_found  = n_detected;
        n_result.noise_count     = n_noisy;
        n_result.last_sync_width = n_sync_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cap   <= '0;
            r_sync_width <= '0;
            r_active     <= 1'b0;
            r_pulse_idx  <= '0;
            r_detected   <= '0;
            r_noisy      <= '0;
            r_frame_cnt  <= '0;
            r_reported   <= '0;
            r_valid_tmr  <= '0;
            r_gap_tmr    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pending[i]   <= '0;
                r_published[i] <= '0;
            end
        end else if (i_fire) begin
            r_prev_cap   <= n_prev_cap;
            r_sync_width <= n_sync_width;
            r_active     <= n_active;
            r_pulse_idx  <= n_pulse_idx;
            r_detected   <= n_detected;
            r_noisy      <= n_noisy;
            r_frame_cnt  <= n_frame_cnt;
            r_reported   <= n_reported;
            r_valid_tmr  <= n_valid_tmr;
            r_gap_tmr    <= n_gap_tmr;
            r_pending    <= n_pending;
            r_published  <= n_published;
        end
    end

    assign o_result = n_result;

endmodule

// ===== hw/rtl/ppm_out_buf.sv =====
// Two-entry result buffer of the PPM frame decoder; parts the core from the receiver.
// Depends on ppm_pkg for t_result.
module ppm_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  ppm_pkg::t_result i_wr_data,
    output logic             o_wr_ready,
    output logic             o_valid,
    input  logic             i_rd_ready,
    output ppm_pkg::t_result o_data
);
    import ppm_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       n_rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign n_rd_en    = o_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_wr_en, n_rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ppm_frame_decoder.sv =====
// Top level of the PPM frame decoder: input register, decoder core, result buffer.
// Depends on ppm_pkg, ppm_if, ppm_cfg_regs, ppm_core and ppm_out_buf.
//
// Usage:
//   i_in carries one transaction per item: a capture edge with its 16-bit microsecond
//   timestamp, a millisecond tick, a new-frame poll, or a channel read.
//   o_out returns exactly one result per item, in order, with status, channel width,
//   frame number and the decoder's channel count, noise count and last sync width.
//   i_cfg writes the eight setup registers by index; ready is always high. Write it only
//   while no item is in flight.
// Path: an accepted item is held in the input register, then the single-pass update
//   writes its result into the result buffer, where it stays valid until taken; while
//   the buffer is full the item waits in the input register.
// Throughput: one item per cycle unless the result buffer is full; state updates in the
//   same cycle an item leaves the input register, so each sees the prior item's state.
// Reset: synchronous, active low; clears decoder state, both width tables, the
//   registers to their defaults, and empties the pipeline.
// Stall: the two-entry result buffer holds results while o_out.ready is low; once it
//   is full an item in the input register holds there and i_in.ready drops.
module ppm_frame_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppm_in_if.sink    i_in,
    ppm_out_if.source o_out,
    ppm_cfg_if.sink   i_cfg
);
    import ppm_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    t_cfg    n_cfg;
    t_result n_core_result;
    t_result n_buf_data;
    logic    n_buf_ready;
    logic    n_fire;

    assign n_fire     = r_in_valid && n_buf_ready;
    assign i_in.ready = !r_in_valid || n_fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.op           <= t_op'(i_in.operation);
            r_item.capture_time <= i_in.capture_time;
            r_item.channel      <= i_in.channel;
        end
    end

    ppm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg.valid && i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (n_cfg)
    );

    ppm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (n_fire),
        .i_item   (r_item),
        .i_cfg    (n_cfg),
        .o_result (n_core_result)
    );

    ppm_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (n_fire),
        .i_wr_data  (n_core_result),
        .o_wr_ready (n_buf_ready),
        .o_valid    (o_out.valid),
        .i_rd_ready (o_out.ready),
        .o_data     (n_buf_data)
    );

    assign o_out.status          = n_buf_data.status;
    assign o_out.channel_width   = n_buf_data.channel_width;
    assign o_out.frame_number    = n_buf_data.frame_number;
    assign o_out.channels_found  = n_buf_data.channels_found;
    assign o_out.noise_count     = n_buf_data.noise_count;
    assign o_out.last_sync_width = n_buf_data.last_sync_width;

endmodule

// ===== hw/rtl/ppm_checker.sv =====
// Port-level checks of the PPM frame decoder, bound to the top level.
// Depends on ppm_frame_decoder and the channel interfaces in ppm_if.
module ppm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [15:0] i_out_channel_width,
    input logic [31:0] i_out_frame_number,
    input logic [7:0]  i_out_noise_count,
    input logic [15:0] i_out_last_sync_width
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_channel_width) && $stable(i_out_frame_number))
        else $error("stalled result changed");

    a_no_result_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    a_noise_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_last_sync_width == 16'd0) |-> (i_out_noise_count == 8'd0))
        else $error("noise counted without a sync");

endmodule

bind ppm_frame_decoder ppm_checker u_ppm_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_ready            (i_in.ready),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_status          (o_out.status),
    .i_out_channel_width   (o_out.channel_width),
    .i_out_frame_number    (o_out.frame_number),
    .i_out_noise_count     (o_out.noise_count),
    .i_out_last_sync_width (o_out.last_sync_width)
);
